@@ sv/ism_pkg.sv @@
`timescale 1ns / 1ps
package ism_pkg;

  localparam int unsigned VAL_W   = 63;
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned HIT_W   = 32;
  localparam int unsigned TOTAL_W = 64;
  localparam int unsigned DEF_TABLE_DEPTH = 1024;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 2'd0,
    FN_QUERY  = 2'd1,
    FN_TOTAL  = 2'd2,
    FN_NONE   = 2'd3
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_CHK,
    S_INS_RD,
    S_INS_WR,
    S_INS_PUT,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_MERGE_WR,
    S_CMP_RD,
    S_CMP_WR,
    S_TOT_RD,
    S_TOT_ACC,
    S_DONE
  } state_e;

endpackage

@@ sv/ism_in_if.sv @@
`timescale 1ns / 1ps
interface ism_in_if;
  import ism_pkg::*;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [VAL_W-1:0]  range_low;
  logic [VAL_W-1:0]  range_high;
  logic [VAL_W-1:0]  item_id;
  modport source (output valid, func, range_low, range_high, item_id, input ready);
  modport sink   (input valid, func, range_low, range_high, item_id, output ready);
endinterface

@@ sv/ism_out_if.sv @@
`timescale 1ns / 1ps
interface ism_out_if;
  import ism_pkg::*;
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic               is_member;
  logic [HIT_W-1:0]   hit_total;
  logic [TOTAL_W-1:0] covered_total;
  modport source (output valid, status, is_member, hit_total, covered_total, input ready);
  modport sink   (input valid, status, is_member, hit_total, covered_total, output ready);
endinterface

@@ sv/interval_set_membership_core.sv @@
`timescale 1ns / 1ps
// Sorted table of disjoint ranges held in one synchronous memory (one read and
// one write port, registered read); one word is worked at a time. A query is a
// bisection search over the memory and a check of the entry found. An insert
// does the same search, then shifts entries up to open a slot, or writes the
// merged range and moves later entries down to close the gap. A total reads
// and sums every stored entry. The result word waits in an output register.
module interval_set_membership_core
  import ism_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  ism_in_if.sink    in_i,
  ism_out_if.source out_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [HIT_W-1:0] HIT_MAX = '1;

  logic [2*VAL_W-1:0] mem_q [TABLE_DEPTH];
  logic [2*VAL_W-1:0] rdata_q;
  logic               rd_en, wr_en;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic [2*VAL_W-1:0] wr_data;
  logic [VAL_W-1:0]   rd_start, rd_end;

  state_e state_q, state_d;
  logic [FUNC_W-1:0]  func_q, func_d;
  logic [VAL_W-1:0]   lo_q, lo_d, hi_q, hi_d, id_q, id_d, endj_q, endj_d, key;
  logic [CW-1:0]      cnt_q, cnt_d, slo_q, slo_d, shi_q, shi_d, mid_q, mid_d;
  logic [CW-1:0]      i_q, i_d, j_q, j_d, k_q, k_d, gap;
  logic [HIT_W-1:0]   hits_q, hits_d;
  logic [TOTAL_W-1:0] sum_q, sum_d, len;
  logic [TOTAL_W:0]   sum_w;
  logic [STAT_W-1:0]  st_q, st_d;
  logic               mb_q, mb_d;

  logic               ov_q, ov_d, mbo_q, mbo_d;
  logic [STAT_W-1:0]  sto_q, sto_d;
  logic [HIT_W-1:0]   hito_q, hito_d;
  logic [TOTAL_W-1:0] toto_q, toto_d;

  assign rd_start = rdata_q[2*VAL_W-1:VAL_W];
  assign rd_end   = rdata_q[VAL_W-1:0];
  assign key      = (func_q == FN_INSERT) ? lo_q : id_q;
  assign gap      = j_q - i_q;
  assign len      = {1'b0, rd_end} - {1'b0, rd_start} + TOTAL_W'(1);
  assign sum_w    = {1'b0, sum_q} + {1'b0, len};

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= mem_q[rd_addr];
  end

  always_comb begin
    state_d = state_q;
    func_d = func_q; lo_d = lo_q; hi_d = hi_q; id_d = id_q; endj_d = endj_q;
    cnt_d = cnt_q; slo_d = slo_q; shi_d = shi_q; mid_d = mid_q;
    i_d = i_q; j_d = j_q; k_d = k_q; hits_d = hits_q; sum_d = sum_q;
    st_d = st_q; mb_d = mb_q;
    ov_d = ov_q && !out_o.ready;
    sto_d = sto_q; mbo_d = mbo_q; hito_d = hito_q; toto_d = toto_q;
    rd_en = 1'b0; rd_addr = '0; wr_en = 1'b0; wr_addr = '0; wr_data = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          func_d = in_i.func; lo_d = in_i.range_low; hi_d = in_i.range_high;
          id_d = in_i.item_id;
          st_d = ST_OK; mb_d = 1'b0; sum_d = '0; k_d = '0;
          slo_d = '0; shi_d = cnt_q;
          unique case (in_i.func)
            FN_INSERT: begin
              if (in_i.range_low > in_i.range_high) begin
                st_d = ST_BAD; state_d = S_DONE;
              end else state_d = S_SRCH_RD;
            end
            FN_QUERY: state_d = S_SRCH_RD;
            FN_TOTAL: state_d = S_TOT_RD;
            default:  state_d = S_DONE;
          endcase
        end
      end
      S_SRCH_RD: begin
        if (slo_q < shi_q) begin
          mid_d = slo_q + ((shi_q - slo_q) >> 1);
          rd_en = 1'b1; rd_addr = mid_d[AW-1:0];
          state_d = S_SRCH_CMP;
        end else begin
          i_d = slo_q;
          if (slo_q < cnt_q) begin
            rd_en = 1'b1; rd_addr = slo_q[AW-1:0];
            state_d = S_CHK;
          end else if (func_q == FN_QUERY) begin
            state_d = S_DONE;
          end else if (cnt_q == DEPTH_C) begin
            st_d = ST_FULL; state_d = S_DONE;
          end else begin
            k_d = cnt_q;
            state_d = (cnt_q > slo_q) ? S_INS_RD : S_INS_PUT;
          end
        end
      end
      S_SRCH_CMP: begin
        if (rd_end < key) slo_d = mid_q + CW'(1);
        else shi_d = mid_q;
        state_d = S_SRCH_RD;
      end
      S_CHK: begin
        if (func_q == FN_QUERY) begin
          if (rd_start <= id_q) begin
            mb_d = 1'b1;
            if (hits_q != HIT_MAX) hits_d = hits_q + HIT_W'(1);
          end
          state_d = S_DONE;
        end else if (rd_start > hi_q) begin
          if (cnt_q == DEPTH_C) begin
            st_d = ST_FULL; state_d = S_DONE;
          end else begin
            k_d = cnt_q;
            state_d = (cnt_q > i_q) ? S_INS_RD : S_INS_PUT;
          end
        end else begin
          if (rd_start < lo_q) lo_d = rd_start;
          endj_d = rd_end; j_d = i_q;
          state_d = S_SCAN_RD;
        end
      end
      S_INS_RD: begin
        rd_en = 1'b1; rd_addr = AW'(k_q - CW'(1));
        state_d = S_INS_WR;
      end
      S_INS_WR: begin
        wr_en = 1'b1; wr_addr = k_q[AW-1:0]; wr_data = rdata_q;
        k_d = k_q - CW'(1);
        state_d = (k_d > i_q) ? S_INS_RD : S_INS_PUT;
      end
      S_INS_PUT: begin
        wr_en = 1'b1; wr_addr = i_q[AW-1:0]; wr_data = {lo_q, hi_q};
        cnt_d = cnt_q + CW'(1);
        state_d = S_DONE;
      end
      S_SCAN_RD: begin
        if ({1'b0, j_q} + (CW+1)'(1) < {1'b0, cnt_q}) begin
          rd_en = 1'b1; rd_addr = AW'(j_q + CW'(1));
          state_d = S_SCAN_CMP;
        end else state_d = S_MERGE_WR;
      end
      S_SCAN_CMP: begin
        if (rd_start <= hi_q) begin
          j_d = j_q + CW'(1); endj_d = rd_end;
          state_d = S_SCAN_RD;
        end else state_d = S_MERGE_WR;
      end
      S_MERGE_WR: begin
        if (endj_q > hi_q) hi_d = endj_q;
        wr_en = 1'b1; wr_addr = i_q[AW-1:0]; wr_data = {lo_q, hi_d};
        k_d = i_q + CW'(1);
        state_d = S_CMP_RD;
      end
      S_CMP_RD: begin
        if (gap != '0 && ({1'b0, k_q} + {1'b0, gap} < {1'b0, cnt_q})) begin
          rd_en = 1'b1; rd_addr = AW'(k_q + gap);
          state_d = S_CMP_WR;
        end else begin
          cnt_d = cnt_q - gap;
          state_d = S_DONE;
        end
      end
      S_CMP_WR: begin
        wr_en = 1'b1; wr_addr = k_q[AW-1:0]; wr_data = rdata_q;
        k_d = k_q + CW'(1);
        state_d = S_CMP_RD;
      end
      S_TOT_RD: begin
        if (k_q < cnt_q) begin
          rd_en = 1'b1; rd_addr = k_q[AW-1:0];
          state_d = S_TOT_ACC;
        end else state_d = S_DONE;
      end
      S_TOT_ACC: begin
        if (sum_w[TOTAL_W]) begin
          sum_d = '1; state_d = S_DONE;
        end else begin
          sum_d = sum_w[TOTAL_W-1:0];
          k_d = k_q + CW'(1);
          state_d = S_TOT_RD;
        end
      end
      S_DONE: begin
        if (!ov_q || out_o.ready) begin
          ov_d = 1'b1; sto_d = st_q; mbo_d = mb_q; hito_d = hits_q;
          toto_d = (func_q == FN_TOTAL) ? sum_q : '0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready          = (state_q == S_IDLE);
    out_o.valid         = ov_q;
    out_o.status        = sto_q;
    out_o.is_member     = mbo_q;
    out_o.hit_total     = hito_q;
    out_o.covered_total = toto_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      hits_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      hits_q  <= hits_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d; lo_q <= lo_d; hi_q <= hi_d; id_q <= id_d; endj_q <= endj_d;
    slo_q <= slo_d; shi_q <= shi_d; mid_q <= mid_d;
    i_q <= i_d; j_q <= j_d; k_q <= k_d; sum_q <= sum_d;
    st_q <= st_d; mb_q <= mb_d;
    sto_q <= sto_d; mbo_q <= mbo_d; hito_q <= hito_d; toto_q <= toto_d;
  end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import ism_pkg::*;

  localparam int unsigned DEPTH = DEF_TABLE_DEPTH;
  localparam logic [VAL_W-1:0] VMAX = {VAL_W{1'b1}};
  localparam logic [VAL_W-1:0] FILL_BASE = 63'h4000_0000_0000_0000;

  typedef struct packed {
    status_e            status;
    logic               member;
    logic [HIT_W-1:0]   hits;
    logic [TOTAL_W-1:0] covered;
  } answer_t;

  class range_table_sb;
    logic [VAL_W-1:0] lo_tab[DEPTH];
    logic [VAL_W-1:0] hi_tab[DEPTH];
    int unsigned      used;
    int unsigned      peak;
    logic [HIT_W-1:0] hit_cnt;
    answer_t          answers_q[$];

    function new();
      used = 0;
      peak = 0;
      hit_cnt = '0;
    endfunction

    function int unsigned first_end_ge(logic [VAL_W-1:0] v);
      int unsigned a, b, m;
      a = 0;
      b = used;
      while (a < b) begin
        m = a + (b - a) / 2;
        if (hi_tab[m] < v) a = m + 1;
        else b = m;
      end
      return a;
    endfunction

    function status_e merge_range(logic [VAL_W-1:0] lo, logic [VAL_W-1:0] hi);
      int unsigned i, j, k, gap;
      if (lo > hi) return ST_BAD;
      i = first_end_ge(lo);
      if (i >= used || lo_tab[i] > hi) begin
        if (used >= DEPTH) return ST_FULL;
        for (k = used; k > i; k--) begin
          lo_tab[k] = lo_tab[k-1];
          hi_tab[k] = hi_tab[k-1];
        end
        lo_tab[i] = lo;
        hi_tab[i] = hi;
        used++;
        if (used > peak) peak = used;
        return ST_OK;
      end
      j = i;
      while (j + 1 < used && lo_tab[j+1] <= hi) j++;
      if (lo_tab[i] < lo) lo = lo_tab[i];
      if (hi_tab[j] > hi) hi = hi_tab[j];
      lo_tab[i] = lo;
      hi_tab[i] = hi;
      if (j > i) begin
        gap = j - i;
        for (k = i + 1; k + gap < used; k++) begin
          lo_tab[k] = lo_tab[k+gap];
          hi_tab[k] = hi_tab[k+gap];
        end
        used -= gap;
      end
      return ST_OK;
    endfunction

    function logic [TOTAL_W-1:0] union_size();
      logic [TOTAL_W:0] sum;
      sum = '0;
      for (int unsigned k = 0; k < used; k++) begin
        sum = sum + (hi_tab[k] - lo_tab[k]) + 1;
        if (sum[TOTAL_W]) return {TOTAL_W{1'b1}};
      end
      return sum[TOTAL_W-1:0];
    endfunction

    function void note_word(func_e fn, logic [VAL_W-1:0] lo, logic [VAL_W-1:0] hi,
                            logic [VAL_W-1:0] id);
      answer_t a;
      int unsigned i;
      a = '0;
      a.status = ST_OK;
      case (fn)
        FN_INSERT: a.status = merge_range(lo, hi);
        FN_QUERY: begin
          i = first_end_ge(id);
          if (i < used && lo_tab[i] <= id) begin
            a.member = 1'b1;
            if (hit_cnt != {HIT_W{1'b1}}) hit_cnt++;
          end
        end
        FN_TOTAL: a.covered = union_size();
        default: ;
      endcase
      a.hits = hit_cnt;
      answers_q = {answers_q, a};
    endfunction

    function string check_word(logic [STAT_W-1:0] st, logic mem, logic [HIT_W-1:0] hits,
                               logic [TOTAL_W-1:0] cov);
      answer_t a;
      if (answers_q.size() == 0) return "result word with nothing expected";
      a = answers_q.pop_front();
      if (st !== a.status || mem !== a.member || hits !== a.hits || cov !== a.covered)
        return $sformatf("got st=%0d mem=%0d hit=%0d cov=%0d, want st=%0d mem=%0d hit=%0d cov=%0d",
                         st, mem, hits, cov, a.status, a.member, a.hits, a.covered);
      return "";
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   errors = 0;
  int   src_idle = 0;
  int   rcv_idle = 0;
  int   n_ins = 0, n_qry = 0, n_tot = 0;
  range_table_sb sb = new();

  ism_in_if  in_if();
  ism_out_if out_if();

  interval_set_membership_core dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic report(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    string msg;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        msg = sb.check_word(out_if.status, out_if.is_member, out_if.hit_total,
                            out_if.covered_total);
        if (msg != "") report(msg);
      end
      out_if.ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  task automatic send_word(func_e fn, logic [VAL_W-1:0] lo, logic [VAL_W-1:0] hi,
                           logic [VAL_W-1:0] id);
    if ($urandom_range(99) < src_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < src_idle) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.func       <= fn;
    in_if.range_low  <= lo;
    in_if.range_high <= hi;
    in_if.item_id    <= id;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_word(fn, lo, hi, id);
    case (fn)
      FN_INSERT: n_ins++;
      FN_QUERY:  n_qry++;
      FN_TOTAL:  n_tot++;
      default: ;
    endcase
  endtask

  function automatic logic [VAL_W-1:0] any_val();
    return VAL_W'({$urandom, $urandom});
  endfunction

  function automatic logic [VAL_W-1:0] window_val();
    return VAL_W'($urandom_range(4000));
  endfunction

  function automatic logic [VAL_W-1:0] probe_id();
    int unsigned k;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 30 && sb.used > 0) begin
      k = $urandom_range(sb.used - 1);
      case ($urandom_range(3))
        0: return sb.lo_tab[k];
        1: return sb.hi_tab[k];
        2: return sb.hi_tab[k] + 1;
        default: return sb.lo_tab[k] - 1;
      endcase
    end
    if (r < 40) return any_val();
    return window_val();
  endfunction

  task automatic random_word();
    logic [VAL_W-1:0] lo, hi;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) begin
      if ($urandom_range(19) == 0) begin
        lo = any_val() >> 1;
        hi = lo + $urandom_range(1000);
      end else begin
        lo = window_val();
        hi = lo + $urandom_range(20);
      end
      if ($urandom_range(19) == 0) begin
        hi = lo;
        lo = lo + 1 + $urandom_range(5);
      end
      send_word(FN_INSERT, lo, hi, any_val());
    end else if (r < 88) begin
      send_word(FN_QUERY, any_val(), any_val(), probe_id());
    end else if (r < 95) begin
      send_word(FN_TOTAL, any_val(), any_val(), any_val());
    end else begin
      send_word(FN_NONE, any_val(), any_val(), any_val());
    end
  endtask

  initial begin
    #200_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic [VAL_W-1:0] k;
    in_if.valid      = 1'b0;
    in_if.func       = '0;
    in_if.range_low  = '0;
    in_if.range_high = '0;
    in_if.item_id    = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, touching and merging ranges, extremes, bad range
    send_word(FN_QUERY, '0, '0, 63'd5);
    send_word(FN_TOTAL, '0, '0, '0);
    send_word(FN_INSERT, 63'd10, 63'd20, '0);
    send_word(FN_INSERT, 63'd5, 63'd4, '0);
    send_word(FN_INSERT, 63'd1, 63'd3, '0);
    send_word(FN_INSERT, 63'd4, 63'd5, '0);
    send_word(FN_QUERY, '0, '0, 63'd3);
    send_word(FN_QUERY, '0, '0, 63'd4);
    send_word(FN_QUERY, '0, '0, 63'd6);
    send_word(FN_INSERT, '0, '0, VMAX);
    send_word(FN_INSERT, VMAX, VMAX, '0);
    send_word(FN_INSERT, VMAX, '0, VMAX);
    send_word(FN_QUERY, VMAX, VMAX, VMAX);
    send_word(FN_QUERY, '0, '0, '0);
    send_word(FN_TOTAL, VMAX, VMAX, VMAX);
    send_word(FN_INSERT, 63'd2, 63'd12, '0);
    send_word(FN_TOTAL, '0, '0, '0);
    send_word(FN_NONE, VMAX, VMAX, VMAX);
    send_word(FN_INSERT, VMAX - 1, VMAX, '0);
    send_word(FN_INSERT, 63'd30, 63'd40, '0);
    send_word(FN_QUERY, '0, '0, 63'd21);
    send_word(FN_TOTAL, '0, '0, '0);

    src_idle = 32; rcv_idle = 60;
    repeat (100) random_word();
    src_idle = 60; rcv_idle = 32;
    repeat (100) random_word();
    src_idle = 0; rcv_idle = 0;
    repeat (100) random_word();

    // fill the table, then drive inserts against a full table
    k = FILL_BASE;
    while (sb.used < DEPTH) begin
      send_word(FN_INSERT, k, k + 1, '0);
      k = k + 4;
    end
    repeat (4) begin
      send_word(FN_INSERT, k, k + 1, '0);
      k = k + 4;
    end
    send_word(FN_INSERT, k - 4, k - 3, '0);
    send_word(FN_INSERT, FILL_BASE + 1, FILL_BASE + 9, '0);
    send_word(FN_INSERT, k + 10, k + 12, '0);
    send_word(FN_TOTAL, '0, '0, '0);
    repeat (40) send_word(FN_QUERY, any_val(), any_val(), probe_id());
    send_word(FN_TOTAL, '0, '0, '0);

    in_if.valid <= 1'b0;
    while (sb.answers_q.size() != 0) @(posedge clk_i);
    repeat (3000) @(posedge clk_i);

    $display("Covered %0d inserts, %0d queries, %0d totals; table peak %0d of %0d entries.",
             n_ins, n_qry, n_tot, sb.peak, DEPTH);
    $display("Mismatches: %0d", errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/ism_pkg.sv
sv/ism_in_if.sv
sv/ism_out_if.sv
sv/interval_set_membership_core.sv
verif/tb_top.sv
